[sv/afps_pkg.sv]
package afps_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 1024;
  localparam int unsigned MAX_PEAKS_DEF   = 64;
  localparam int unsigned MAX_DEC_DEF     = 16;

  localparam int unsigned HOP_W   = 11;
  localparam int unsigned DEC_W   = 5;
  localparam int unsigned PEAKS_W = 7;
  localparam int unsigned BIN_W   = 8;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TW_W    = 19;
  localparam int unsigned PWR_W   = 64;

  localparam logic [BIN_W-1:0]   BIN_CLAMP = 8'd255;
  localparam logic [HOP_W-1:0]   HOP_RST   = 11'd256;
  localparam logic [DEC_W-1:0]   DEC_RST   = 5'd4;
  localparam logic [PEAKS_W-1:0] PEAKS_RST = 7'd4;

  typedef enum logic [1:0] {
    REG_HOP   = 2'd0,
    REG_DEC   = 2'd1,
    REG_PEAKS = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_BF_RD_B,
    OP_BF_RD_A,
    OP_BF_M0,
    OP_BF_M1,
    OP_BF_M2,
    OP_BF_M3,
    OP_BF_M4,
    OP_BF_WA,
    OP_BF_WB,
    OP_PW_RD,
    OP_PW_SQ0,
    OP_PW_SQ1,
    OP_PW_WR,
    OP_SC_RUN,
    OP_SC_TAIL,
    OP_SC_EMIT
  } afps_op_t;

  typedef struct packed {
    afps_op_t op;
    logic     take;
  } afps_cmd_t;

  typedef struct packed {
    logic start;
    logic full_last;
    logic half_last;
    logic stage_last;
    logic rank_last;
    logic out_free;
  } afps_sts_t;

  // twiddle {cos, sin} in q1.17 for index k of an fft of 2**log2n points
  function automatic logic [2*TW_W-1:0] tw_entry(int unsigned k, int unsigned log2n);
    longint unsigned n_pts;
    longint unsigned q;
    longint unsigned th;
    longint unsigned t2;
    longint unsigned mag;
    longint signed   c;
    longint signed   s;
    logic            neg;
    logic signed [TW_W-1:0] cq;
    logic signed [TW_W-1:0] sq;
    n_pts = 64'd1 << log2n;
    q     = 64'(k);
    neg   = 1'b0;
    if (64'(4 * k) > n_pts) begin
      q   = (n_pts >> 1) - 64'(k);
      neg = 1'b1;
    end
    th  = (64'd6746518852 * q + (n_pts >> 1)) >> log2n;
    t2  = (th * th) >> 30;
    c   = 64'sd1 <<< 30;
    mag = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      mag = ((mag * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) c = c - $signed(mag);
      else c = c + $signed(mag);
    end
    s   = $signed(th);
    mag = th;
    for (int n = 1; n <= 12; n++) begin
      mag = ((mag * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - $signed(mag);
      else s = s + $signed(mag);
    end
    c  = (c + 64'sd4096) >>> 13;
    s  = (s + 64'sd4096) >>> 13;
    cq = TW_W'(c);
    sq = TW_W'(s);
    if (neg) cq = -cq;
    return {cq, sq};
  endfunction

endpackage

[sv/afps_ram.sv]
module afps_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/afps_ctrl.sv]
module afps_ctrl
  import afps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  afps_sts_t sts,
  output afps_cmd_t cmd,
  output logic      in_stall
);

  afps_op_t state_r, state_nxt;
  logic     take;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= OP_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    take      = (state_r == OP_IDLE) && in_valid;
    state_nxt = state_r;
    unique case (state_r)
      OP_IDLE:    if (take && sts.start) state_nxt = OP_LOAD_RD;
      OP_LOAD_RD: state_nxt = OP_LOAD_WR;
      OP_LOAD_WR: state_nxt = sts.full_last ? OP_BF_RD_B : OP_LOAD_RD;
      OP_BF_RD_B: state_nxt = OP_BF_RD_A;
      OP_BF_RD_A: state_nxt = OP_BF_M0;
      OP_BF_M0:   state_nxt = OP_BF_M1;
      OP_BF_M1:   state_nxt = OP_BF_M2;
      OP_BF_M2:   state_nxt = OP_BF_M3;
      OP_BF_M3:   state_nxt = OP_BF_M4;
      OP_BF_M4:   state_nxt = OP_BF_WA;
      OP_BF_WA:   state_nxt = OP_BF_WB;
      OP_BF_WB: begin
        if (sts.half_last && sts.stage_last) state_nxt = OP_PW_RD;
        else state_nxt = OP_BF_RD_B;
      end
      OP_PW_RD:   state_nxt = OP_PW_SQ0;
      OP_PW_SQ0:  state_nxt = OP_PW_SQ1;
      OP_PW_SQ1:  state_nxt = OP_PW_WR;
      OP_PW_WR:   state_nxt = sts.half_last ? OP_SC_RUN : OP_PW_RD;
      OP_SC_RUN:  if (sts.half_last) state_nxt = OP_SC_TAIL;
      OP_SC_TAIL: state_nxt = OP_SC_EMIT;
      OP_SC_EMIT: begin
        if (sts.out_free) state_nxt = sts.rank_last ? OP_IDLE : OP_SC_RUN;
      end
      default:    state_nxt = OP_IDLE;
    endcase
  end

  assign cmd.op   = state_r;
  assign cmd.take = take;
  assign in_stall = (state_r != OP_IDLE);

endmodule

[sv/afps_dp.sv]
module afps_dp
  import afps_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE    = WINDOW_SIZE_DEF,
  parameter int unsigned MAX_PEAKS      = MAX_PEAKS_DEF,
  parameter int unsigned MAX_DECIMATION = MAX_DEC_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  afps_cmd_t               cmd,
  output afps_sts_t               sts,
  input  logic [HOP_W-1:0]        hop,
  input  logic [DEC_W-1:0]        decimation,
  input  logic [PEAKS_W-1:0]      peaks,
  input  logic signed [SMP_W-1:0] left_sample,
  input  logic signed [SMP_W-1:0] right_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BIN_W-1:0]        out_peak_bin,
  output logic [RANK_W-1:0]       out_peak_rank,
  output logic                    out_last_peak
);

  localparam int unsigned LOG2N = $clog2(WINDOW_SIZE);
  localparam int unsigned HALF  = WINDOW_SIZE / 2;
  localparam int unsigned HK_W  = LOG2N - 1;
  localparam int unsigned SW    = 18 + $clog2(MAX_DECIMATION);
  localparam int unsigned DW    = SW + LOG2N + 1;
  localparam int unsigned PR_W  = DW + TW_W;
  localparam int unsigned GC_W  = $clog2(MAX_DECIMATION + 1);
  localparam int unsigned ST_W  = $clog2(LOG2N);
  localparam int unsigned LIM   = (MAX_PEAKS < HALF) ? MAX_PEAKS : HALF;
  localparam int unsigned KX_W  = HK_W + BIN_W;

  // input grouping and window bookkeeping
  logic signed [SW-1:0] group_sum_r;
  logic [GC_W-1:0]      group_cnt_r;
  logic [LOG2N-1:0]     wr_pos_r;
  logic [LOG2N:0]       fill_r;
  logic [HOP_W-1:0]     hop_cnt_r;

  logic signed [SW-1:0] sum_nxt;
  logic [GC_W-1:0]      cnt_inc;
  logic [GC_W-1:0]      dec_eff;
  logic [HOP_W-1:0]     hop_eff;
  logic [HOP_W-1:0]     hop_inc;
  logic                 full;
  logic                 close;

  // sequencing
  logic [LOG2N-1:0] idx_r;
  logic [ST_W-1:0]  stage_r;
  logic [PEAKS_W-1:0] rank_r;
  logic [PEAKS_W-1:0] cnt_eff;

  // butterfly
  logic [HK_W-1:0]    bf;
  logic [HK_W-1:0]    jmask;
  logic [HK_W-1:0]    j_off;
  logic [HK_W-1:0]    widx;
  logic [ST_W:0]      st1;
  logic [LOG2N-1:0]   a_addr;
  logic [LOG2N-1:0]   b_addr;
  logic [LOG2N-1:0]   rev_idx;
  logic [2*TW_W-1:0]  tw_tab [HALF];
  logic [2*TW_W-1:0]  tw_r;
  logic signed [TW_W-1:0] wc;
  logic signed [TW_W-1:0] ws;
  logic signed [DW-1:0]   br_r, bi_r, ar_r, ai_r, tr_r, ti_r;
  logic signed [DW-1:0]   m_a;
  logic signed [TW_W-1:0] m_b;
  logic signed [PR_W-1:0] prod_r, acc_r;
  logic signed [PR_W:0]   rsum;

  // power
  logic signed [DW-1:0] sq_in;
  logic [DW-1:0]        mag_u;
  logic [63:0]          mag64;
  logic [31:0]          m32;
  logic [PWR_W-1:0]     sq_r, acc64_r;
  logic [PWR_W:0]       psum;

  // scan
  logic               scan_vld_r;
  logic [HK_W-1:0]    scan_k_r;
  logic [PWR_W-1:0]   best_p_r, prev_p_r;
  logic [HK_W-1:0]    best_k_r, prev_k_r;
  logic               have_r;
  logic               elig;
  logic [KX_W-1:0]    kx;

  // output register
  logic              out_valid_r;
  logic [BIN_W-1:0]  out_bin_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_last_r;

  // memories
  logic                 win_we, win_re;
  logic [LOG2N-1:0]     win_raddr;
  logic [SW-1:0]        win_rdata;
  logic                 wk_we, wk_re;
  logic [LOG2N-1:0]     wk_waddr, wk_raddr;
  logic [2*DW-1:0]      wk_wdata, wk_rdata;
  logic                 pw_we, pw_re;
  logic [PWR_W-1:0]     pw_rdata;

  always_comb begin
    sum_nxt = group_sum_r + SW'(left_sample) + SW'(right_sample);
    cnt_inc = group_cnt_r + 1'b1;
    if (decimation == '0) dec_eff = GC_W'(1);
    else if (32'(decimation) > MAX_DECIMATION) dec_eff = GC_W'(MAX_DECIMATION);
    else dec_eff = GC_W'(decimation);
    hop_eff = (hop == '0) ? HOP_W'(1) : hop;
    hop_inc = hop_cnt_r + 1'b1;
    full    = (fill_r == (LOG2N+1)'(WINDOW_SIZE));
    close   = (cnt_inc >= dec_eff);
    if (32'(peaks) > LIM) cnt_eff = PEAKS_W'(LIM);
    else if (peaks == '0) cnt_eff = PEAKS_W'(1);
    else cnt_eff = peaks;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_sum_r <= '0;
      group_cnt_r <= '0;
      wr_pos_r    <= '0;
      fill_r      <= '0;
      hop_cnt_r   <= '0;
    end else if (cmd.take) begin
      if (close) begin
        group_sum_r <= '0;
        group_cnt_r <= '0;
        wr_pos_r    <= wr_pos_r + 1'b1;
        if (!full) begin
          fill_r    <= fill_r + 1'b1;
          hop_cnt_r <= '0;
        end else begin
          hop_cnt_r <= (hop_inc >= hop_eff) ? '0 : hop_inc;
        end
      end else begin
        group_sum_r <= sum_nxt;
        group_cnt_r <= cnt_inc;
      end
    end
  end

  assign win_we    = cmd.take && close;
  assign win_re    = (cmd.op == OP_LOAD_RD);
  assign win_raddr = wr_pos_r + idx_r;

  afps_ram #(.W(SW), .D(WINDOW_SIZE)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (wr_pos_r),
    .wdata (sum_nxt),
    .re    (win_re),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // butterfly addressing
  always_comb begin
    bf      = idx_r[HK_W-1:0];
    st1     = (ST_W+1)'(stage_r) + 1'b1;
    jmask   = (HK_W'(1) << stage_r) - 1'b1;
    j_off   = bf & jmask;
    a_addr  = ((LOG2N'(bf) >> stage_r) << st1) | LOG2N'(j_off);
    b_addr  = a_addr | (LOG2N'(1) << stage_r);
    widx    = j_off << (ST_W'(HK_W) - stage_r);
    for (int b = 0; b < LOG2N; b++) rev_idx[b] = idx_r[LOG2N-1-b];
  end

  for (genvar k = 0; k < HALF; k++) begin : g_tw
    assign tw_tab[k] = tw_entry(k, LOG2N);
  end

  assign wc = tw_r[2*TW_W-1:TW_W];
  assign ws = tw_r[TW_W-1:0];

  always_comb begin
    unique case (cmd.op)
      OP_BF_M1: begin m_a = bi_r; m_b = ws; end
      OP_BF_M2: begin m_a = bi_r; m_b = wc; end
      OP_BF_M3: begin m_a = br_r; m_b = ws; end
      default:  begin m_a = br_r; m_b = wc; end
    endcase
    if (cmd.op == OP_BF_M2) rsum = (PR_W+1)'(acc_r) + (PR_W+1)'(prod_r);
    else rsum = (PR_W+1)'(acc_r) - (PR_W+1)'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_BF_RD_B) tw_r <= tw_tab[widx];
    if (cmd.op == OP_BF_RD_A) begin
      br_r <= wk_rdata[2*DW-1:DW];
      bi_r <= wk_rdata[DW-1:0];
    end
    if (cmd.op == OP_BF_M0) begin
      ar_r <= wk_rdata[2*DW-1:DW];
      ai_r <= wk_rdata[DW-1:0];
    end
    prod_r <= m_a * m_b;
    if (cmd.op == OP_BF_M1 || cmd.op == OP_BF_M3) acc_r <= prod_r;
    if (cmd.op == OP_BF_M2) tr_r <= DW'((rsum + (PR_W+1)'(65536)) >>> 17);
    if (cmd.op == OP_BF_M4) ti_r <= DW'((rsum + (PR_W+1)'(65536)) >>> 17);
  end

  // power
  always_comb begin
    sq_in = (cmd.op == OP_PW_SQ1) ? $signed(wk_rdata[DW-1:0]) : $signed(wk_rdata[2*DW-1:DW]);
    mag_u = sq_in[DW-1] ? DW'(-sq_in) : DW'(sq_in);
    mag64 = 64'(mag_u);
    m32   = (mag64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag64[31:0];
    psum  = {1'b0, acc64_r} + {1'b0, sq_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PW_SQ0 || cmd.op == OP_PW_SQ1) sq_r <= m32 * m32;
    if (cmd.op == OP_PW_SQ1) acc64_r <= sq_r;
  end

  // work memory ports
  always_comb begin
    wk_we    = 1'b0;
    wk_waddr = a_addr;
    wk_wdata = {ar_r + tr_r, ai_r + ti_r};
    wk_re    = 1'b0;
    wk_raddr = idx_r;
    unique case (cmd.op)
      OP_LOAD_WR: begin
        wk_we    = 1'b1;
        wk_waddr = rev_idx;
        wk_wdata = {DW'($signed(win_rdata)), DW'(0)};
      end
      OP_BF_WA: wk_we = 1'b1;
      OP_BF_WB: begin
        wk_we    = 1'b1;
        wk_waddr = b_addr;
        wk_wdata = {ar_r - tr_r, ai_r - ti_r};
      end
      OP_BF_RD_B: begin
        wk_re    = 1'b1;
        wk_raddr = b_addr;
      end
      OP_BF_RD_A: begin
        wk_re    = 1'b1;
        wk_raddr = a_addr;
      end
      OP_PW_RD: wk_re = 1'b1;
      default: ;
    endcase
  end

  afps_ram #(.W(2*DW), .D(WINDOW_SIZE)) u_work_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_waddr),
    .wdata (wk_wdata),
    .re    (wk_re),
    .raddr (wk_raddr),
    .rdata (wk_rdata)
  );

  assign pw_we = (cmd.op == OP_PW_WR);
  assign pw_re = (cmd.op == OP_SC_RUN);

  afps_ram #(.W(PWR_W), .D(HALF)) u_pwr_ram (
    .clk   (clk),
    .we    (pw_we),
    .waddr (idx_r[HK_W-1:0]),
    .wdata (psum[PWR_W] ? {PWR_W{1'b1}} : psum[PWR_W-1:0]),
    .re    (pw_re),
    .raddr (idx_r[HK_W-1:0]),
    .rdata (pw_rdata)
  );

  // sequencing counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      stage_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_IDLE: begin
          idx_r   <= '0;
          stage_r <= '0;
        end
        OP_LOAD_WR: idx_r <= idx_r + 1'b1;
        OP_BF_WB: begin
          if (sts.half_last) begin
            idx_r   <= '0;
            stage_r <= stage_r + 1'b1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        OP_PW_WR, OP_SC_RUN: idx_r <= sts.half_last ? '0 : idx_r + 1'b1;
        default: ;
      endcase
    end
  end

  // strongest remaining bin: below the last one reported in (power desc, index asc) order
  always_comb begin
    elig = (rank_r == '0) || (pw_rdata < prev_p_r) ||
           ((pw_rdata == prev_p_r) && (scan_k_r > prev_k_r));
    kx   = KX_W'(best_k_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
      have_r     <= 1'b0;
      rank_r     <= '0;
    end else begin
      scan_vld_r <= (cmd.op == OP_SC_RUN);
      if (cmd.op == OP_PW_WR && sts.half_last) begin
        have_r <= 1'b0;
        rank_r <= '0;
      end else if (cmd.op == OP_SC_EMIT && sts.out_free) begin
        have_r <= 1'b0;
        rank_r <= rank_r + 1'b1;
      end else if (scan_vld_r && elig && (!have_r || pw_rdata > best_p_r)) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_k_r <= idx_r[HK_W-1:0];
    if (scan_vld_r && elig && (!have_r || pw_rdata > best_p_r)) begin
      best_p_r <= pw_rdata;
      best_k_r <= scan_k_r;
    end
    if (cmd.op == OP_SC_EMIT && sts.out_free) begin
      prev_p_r <= best_p_r;
      prev_k_r <= best_k_r;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_SC_EMIT && sts.out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SC_EMIT && sts.out_free) begin
      out_bin_r  <= (kx > KX_W'(BIN_CLAMP)) ? BIN_CLAMP : kx[BIN_W-1:0];
      out_rank_r <= rank_r[RANK_W-1:0];
      out_last_r <= sts.rank_last;
    end
  end

  assign sts.start      = close && (full ? (hop_inc >= hop_eff)
                                         : (fill_r == (LOG2N+1)'(WINDOW_SIZE - 1)));
  assign sts.full_last  = &idx_r;
  assign sts.half_last  = &idx_r[HK_W-1:0];
  assign sts.stage_last = (stage_r == ST_W'(LOG2N - 1));
  assign sts.rank_last  = ((rank_r + 1'b1) == cnt_eff);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_peak_bin  = out_bin_r;
  assign out_peak_rank = out_rank_r;
  assign out_last_peak = out_last_r;

endmodule

[sv/audio_fft_peak_signature_core.sv]
// spectral-peak signature of a stereo stream
// input channel: one stereo pair per word (in_left_sample, in_right_sample),
// in_valid/in_stall; a word is taken on a clock edge with valid high, stall low.
// output channel: one word per reported peak (bin, rank, last flag), same
// handshake; the last word of an analysis has out_last_peak set.
// config: apb port with hop at 0x0, decimation at 0x4, peaks at 0x8.
// a pair that starts no analysis is taken without a stall. a pair that
// completes an analysis window holds in_stall high while the single fft
// engine runs: it loads the window in bit-reversed order, runs each
// butterfly through one shared multiplier and one work memory read port,
// computes the bin powers, then scans the power memory once per peak.
// the output register decouples the sides: once the last peak is loaded new
// pairs are taken even while it waits; an earlier one waiting stalls emits.
// reset restores the register defaults, empties the window and drops any
// pending result; no memory clearing pass is needed.
module audio_fft_peak_signature_core
  import afps_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE    = WINDOW_SIZE_DEF,
  parameter int unsigned MAX_PEAKS      = MAX_PEAKS_DEF,
  parameter int unsigned MAX_DECIMATION = MAX_DEC_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [ADDR_W-1:0]       cfg_paddr,
  input  logic [DATA_W-1:0]       cfg_pwdata,
  output logic [DATA_W-1:0]       cfg_prdata,
  output logic                    cfg_pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] in_left_sample,
  input  logic signed [SMP_W-1:0] in_right_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [BIN_W-1:0]        out_peak_bin,
  output logic [RANK_W-1:0]       out_peak_rank,
  output logic                    out_last_peak
);

  logic [HOP_W-1:0]   hop_r;
  logic [DEC_W-1:0]   dec_r;
  logic [PEAKS_W-1:0] peaks_r;
  logic               wr_en;
  afps_cmd_t          cmd;
  afps_sts_t          sts;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r   <= HOP_RST;
      dec_r   <= DEC_RST;
      peaks_r <= PEAKS_RST;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_HOP:   hop_r   <= cfg_pwdata[HOP_W-1:0];
        REG_DEC:   dec_r   <= cfg_pwdata[DEC_W-1:0];
        REG_PEAKS: peaks_r <= cfg_pwdata[PEAKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_HOP:   cfg_prdata = DATA_W'(hop_r);
      REG_DEC:   cfg_prdata = DATA_W'(dec_r);
      REG_PEAKS: cfg_prdata = DATA_W'(peaks_r);
      default:   cfg_prdata = '0;
    endcase
  end

  afps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  afps_dp #(
    .WINDOW_SIZE    (WINDOW_SIZE),
    .MAX_PEAKS      (MAX_PEAKS),
    .MAX_DECIMATION (MAX_DECIMATION)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .hop           (hop_r),
    .decimation    (dec_r),
    .peaks         (peaks_r),
    .left_sample   (in_left_sample),
    .right_sample  (in_right_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_peak_bin  (out_peak_bin),
    .out_peak_rank (out_peak_rank),
    .out_last_peak (out_last_peak)
  );

endmodule

[sv/afps_chk.sv]
module afps_chk
  import afps_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    cfg_psel,
  input logic                    cfg_penable,
  input logic                    cfg_pwrite,
  input logic [ADDR_W-1:0]       cfg_paddr,
  input logic [DATA_W-1:0]       cfg_pwdata,
  input logic [DATA_W-1:0]       cfg_prdata,
  input logic                    cfg_pready,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic signed [SMP_W-1:0] in_left_sample,
  input logic signed [SMP_W-1:0] in_right_sample,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [BIN_W-1:0]        out_peak_bin,
  input logic [RANK_W-1:0]       out_peak_rank,
  input logic                    out_last_peak
);

  // reset drops a pending result word
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word survived reset");

  // block is ready for samples right after reset
  a_ready_after_rst: assert property (@(posedge clk) $rose(rst_n) |-> !in_stall)
    else $error("input stalled after reset");

  // while a peak other than the last one is pending, the scan is still running
  a_busy_mid_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_peak |-> in_stall)
    else $error("input taken in the middle of a peak list");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_peak_bin) &&
      $stable(out_peak_rank) && $stable(out_last_peak))
    else $error("stalled result word changed");

endmodule

bind audio_fft_peak_signature_core afps_chk u_afps_chk (.*);
